// File: design/tclod_pkg.sv
// ----------------------------------------------------------------------------
// tclod_pkg
// Shared widths, register indexes, band limits and helper functions for the
// terrain chunk level-of-detail selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tclod_pkg;

   // Field widths
   localparam int CHUNK_W     = 20;
   localparam int CAM_W       = 34;
   localparam int PS_W        = 24;
   localparam int THR_W       = 16;
   localparam int LOD_W       = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 34;

   // Datapath widths
   localparam int NUM_AXES  = 3;
   localparam int NUM_LANES = 4;
   localparam int GAP_W     = 21;               // gap saturates at 2^20 (Q8 meters)
   localparam int D2_W      = 42;               // sum of three squared gaps
   localparam int T_W       = 48;               // threshold^2 * cells^2
   localparam int T_SPLIT   = 24;
   localparam int D_SPLIT   = 21;
   localparam int PP_W      = T_SPLIT + D_SPLIT;
   localparam int RHS_W     = T_W + D2_W;
   localparam int SQ_FRAC_W = 16;               // Q8 squared

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Y        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Z        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_SCALE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_THRESHOLD = 3'd4;

   // Register reset values
   localparam logic [PS_W-1:0]  PS_RESET  = 24'd239437;
   localparam logic [THR_W-1:0] THR_RESET = 16'd512;

   // Per-axis gap limit, 4096 m in Q8
   localparam logic [GAP_W-1:0] GAP_SAT = 21'h10_0000;

   // Squared band limits, Q16 square meters
   localparam logic [D2_W-1:0] BAND_4   = 42'h10_0000_0000;   // 1024 m
   localparam logic [D2_W-1:0] BAND_3   = 42'h04_0000_0000;   // 512 m
   localparam logic [D2_W-1:0] BAND_2   = 42'h01_0000_0000;   // 256 m
   localparam logic [D2_W-1:0] BAND_1   = 42'h00_4000_0000;   // 128 m
   localparam logic [D2_W-1:0] D2_FLOOR = 42'h00_0001_0000;   // 1 m

   // Detail levels
   localparam logic [LOD_W-1:0] LOD_0 = 3'd0;
   localparam logic [LOD_W-1:0] LOD_1 = 3'd1;
   localparam logic [LOD_W-1:0] LOD_2 = 3'd2;
   localparam logic [LOD_W-1:0] LOD_3 = 3'd3;
   localparam logic [LOD_W-1:0] LOD_4 = 3'd4;

   // Square of the cell count at one level, never below one cell
   function automatic int cells_sq(input int fc, input int lvl);
      int c;
      c = fc >> lvl;
      if (c < 1) begin
         c = 1;
      end
      return c * c;
   endfunction

   // Width of 3 * chunk^2 * 65536 * pixel_scale^2
   function automatic int lhs_width(input int cm);
      return $clog2(3 * cm * cm + 1) + 2 * PS_W + SQ_FRAC_W;
   endfunction

endpackage

`default_nettype wire

// File: design/tclod_cfg.sv
// ----------------------------------------------------------------------------
// tclod_cfg
// Configuration registers and the products that depend on them alone: the
// projected chunk size term and the per-level threshold terms.
// ----------------------------------------------------------------------------
`default_nettype none

module tclod_cfg
   import tclod_pkg::*;
#(
   parameter int CHUNK_METERS = 32,
   parameter int FINEST_CELLS = 32
)
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [CSR_INDEX_W-1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wdata,
   output logic [NUM_AXES-1:0][CAM_W-1:0]         cam,
   output logic [lhs_width(CHUNK_METERS)-1:0]     lhs,
   output logic [NUM_LANES-1:0][T_W-1:0]          tcell
);

   localparam int A_VAL  = 3 * CHUNK_METERS * CHUNK_METERS;
   localparam int AW     = $clog2(A_VAL + 1);
   localparam int PS2_W  = 2 * PS_W;
   localparam int THR2_W = 2 * THR_W;
   localparam int LPW    = AW + PS_W;
   localparam int LW     = lhs_width(CHUNK_METERS);
   localparam logic [AW-1:0] A_CONST = AW'(A_VAL);

   logic [NUM_AXES-1:0][CAM_W-1:0]  cam_ff;
   logic [PS_W-1:0]                 ps_ff;
   logic [THR_W-1:0]                thr_ff;
   logic [PS2_W-1:0]                ps2_ff, ps2_in;
   logic [THR2_W-1:0]               thr2_ff, thr2_in;
   logic [LPW-1:0]                  lhi_ff, lhi_in;
   logic [LPW-1:0]                  llo_ff, llo_in;
   logic [LW-1:0]                   lhs_ff, lhs_in;
   logic [NUM_LANES-1:0][T_W-1:0]   tcell_ff, tcell_in;

   // Write one register; ignore indexes past the list
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff <= '0;
         ps_ff  <= PS_RESET;
         thr_ff <= THR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CAMERA_X:        cam_ff[0] <= csr_wdata[CAM_W-1:0];
            CSR_CAMERA_Y:        cam_ff[1] <= csr_wdata[CAM_W-1:0];
            CSR_CAMERA_Z:        cam_ff[2] <= csr_wdata[CAM_W-1:0];
            CSR_PIXEL_SCALE:     ps_ff     <= csr_wdata[PS_W-1:0];
            CSR_ERROR_THRESHOLD: thr_ff    <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Square the scale and the threshold
   always_comb begin
      ps2_in  = PS2_W'(ps_ff) * PS2_W'(ps_ff);
      thr2_in = THR2_W'(thr_ff) * THR2_W'(thr_ff);
   end

   // Multiply the chunk term by each half of scale^2; scale threshold^2 by cells^2
   always_comb begin
      lhi_in = LPW'(A_CONST) * LPW'(ps2_ff[PS2_W-1:PS_W]);
      llo_in = LPW'(A_CONST) * LPW'(ps2_ff[PS_W-1:0]);
      for (int l = 0; l < NUM_LANES; l++) begin
         tcell_in[l] = T_W'(thr2_ff) * T_W'(cells_sq(FINEST_CELLS, l));
      end
   end

   // Join the halves and scale to Q16
   always_comb begin
      lhs_in = ((LW'(lhi_ff) << PS_W) + LW'(llo_ff)) << SQ_FRAC_W;
   end

   // Advance the derived terms every cycle
   always_ff @(posedge clock) begin
      ps2_ff   <= ps2_in;
      thr2_ff  <= thr2_in;
      lhi_ff   <= lhi_in;
      llo_ff   <= llo_in;
      tcell_ff <= tcell_in;
      lhs_ff   <= lhs_in;
   end

   assign cam   = cam_ff;
   assign lhs   = lhs_ff;
   assign tcell = tcell_ff;

endmodule

`default_nettype wire

// File: design/terrain_chunk_lod_select_core.sv
// ----------------------------------------------------------------------------
// terrain_chunk_lod_select_core
// Level-of-detail choice for one terrain chunk per item: distance bands and
// a screen-space error test, coarser of the two wins.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start with the chunk grid index in req_chunk_x/y/z. An
//   item is taken at every rising edge where start is high and busy is low;
//   busy is high only during reset, so one item can enter every cycle.
//   Each result appears on rsp_detail_level with rsp_valid high for one
//   cycle, after the register stages listed below, in item order. The
//   receiver cannot stall; no item waits on the output side.
//   Throughput is one item per cycle: nine register stages (input capture,
//   index scaling, clamped gaps, squares, sum, bands and floor, partial
//   products of the error test, their sum, final compare) each hold one item.
//   Registers are written through csr_valid/csr_ready with csr_index and
//   csr_wdata. After a write, the derived scale and threshold products settle
//   in their registers before any item taken at or after the write needs them.
//   Reset restores the register defaults and drops every item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_chunk_lod_select_core
   import tclod_pkg::*;
#(
   parameter int CHUNK_METERS = 32,
   parameter int FINEST_CELLS = 32
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [CHUNK_W-1:0]     req_chunk_x,
   input  logic signed [CHUNK_W-1:0]     req_chunk_y,
   input  logic signed [CHUNK_W-1:0]     req_chunk_z,
   output logic                          rsp_valid,
   output logic [LOD_W-1:0]              rsp_detail_level,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int LW      = lhs_width(CHUNK_METERS);
   localparam int CW      = (LW > RHS_W) ? LW : RHS_W;
   localparam int CMQ     = CHUNK_METERS * 256;
   localparam int CMQ_W   = $clog2(CMQ + 1);
   localparam int PW      = ((CHUNK_W + CMQ_W + 2 > CAM_W) ? CHUNK_W + CMQ_W + 2 : CAM_W) + 1;
   localparam int NSTAGE  = 8;
   localparam int LATENCY = NSTAGE + 1;
   localparam logic signed [PW-1:0] CMQ_S     = PW'(CMQ);
   localparam logic signed [PW-1:0] ONE_S     = PW'(1);
   localparam logic signed [PW-1:0] GAP_SAT_S = PW'(GAP_SAT);

   logic                              req_accept;
   logic                              csr_write;
   logic [NUM_AXES-1:0][CAM_W-1:0]    cam;
   logic [LW-1:0]                     lhs;
   logic [NUM_LANES-1:0][T_W-1:0]     tcell;
   logic signed [CHUNK_W-1:0]         req_chunk [NUM_AXES];

   // Valid bits of stages 0..7
   logic [NSTAGE-1:0]                 vld_ff, vld_in;

   logic signed [CHUNK_W-1:0]         s0_chunk_ff [NUM_AXES];
   logic signed [PW-1:0]              s1_lo_ff [NUM_AXES], s1_lo_in [NUM_AXES];
   logic signed [PW-1:0]              s1_hi_ff [NUM_AXES], s1_hi_in [NUM_AXES];
   logic signed [PW-1:0]              cam_s [NUM_AXES];
   logic signed [PW-1:0]              d_lo [NUM_AXES];
   logic signed [PW-1:0]              d_hi [NUM_AXES];
   logic signed [PW-1:0]              gap_raw [NUM_AXES];
   logic [GAP_W-1:0]                  s2_gap_ff [NUM_AXES], s2_gap_in [NUM_AXES];
   logic [D2_W-1:0]                   s3_sq_ff [NUM_AXES], s3_sq_in [NUM_AXES];
   logic [D2_W-1:0]                   s4_d2_ff, s4_d2_in;
   logic [D2_W-1:0]                   s5_dfl_ff, s5_dfl_in;
   logic [LOD_W-1:0]                  s5_dist_ff, s5_dist_in;
   logic [NUM_LANES-1:0][PP_W-1:0]    s6_hh_ff, s6_hh_in;
   logic [NUM_LANES-1:0][PP_W-1:0]    s6_hl_ff, s6_hl_in;
   logic [NUM_LANES-1:0][PP_W-1:0]    s6_lh_ff, s6_lh_in;
   logic [NUM_LANES-1:0][PP_W-1:0]    s6_ll_ff, s6_ll_in;
   logic [LOD_W-1:0]                  s6_dist_ff;
   logic [NUM_LANES-1:0][RHS_W-1:0]   s7_rhs_ff, s7_rhs_in;
   logic [LOD_W-1:0]                  s7_dist_ff;
   logic [NUM_LANES-1:0]              lane_pass;
   logic [LOD_W-1:0]                  err_lod;
   logic                              rsp_valid_ff;
   logic [LOD_W-1:0]                  rsp_detail_level_ff, rsp_detail_level_in;

   // Hold off items and writes during reset only
   assign busy       = reset;
   assign csr_ready  = ~reset;
   assign req_accept = start & ~busy;
   assign csr_write  = csr_valid & csr_ready;

   assign req_chunk[0] = req_chunk_x;
   assign req_chunk[1] = req_chunk_y;
   assign req_chunk[2] = req_chunk_z;

   tclod_cfg #(
      .CHUNK_METERS (CHUNK_METERS),
      .FINEST_CELLS (FINEST_CELLS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cam       (cam),
      .lhs       (lhs),
      .tcell     (tcell)
   );

   // Advance valid bits with the data
   assign vld_in = {vld_ff[NSTAGE-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[NSTAGE-1];
      end
   end

   // Stage 1: cube bounds per axis, Q8 meters
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         s1_lo_in[a] = PW'(s0_chunk_ff[a]) * CMQ_S;
         s1_hi_in[a] = (PW'(s0_chunk_ff[a]) + ONE_S) * CMQ_S;
      end
   end

   // Stage 2: clamp camera into the cube, saturate the gap
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         cam_s[a] = PW'($signed(cam[a]));
         d_lo[a]  = s1_lo_ff[a] - cam_s[a];
         d_hi[a]  = cam_s[a] - s1_hi_ff[a];
         priority if (d_lo[a] > 0) begin
            gap_raw[a] = d_lo[a];
         end else if (d_hi[a] > 0) begin
            gap_raw[a] = d_hi[a];
         end else begin
            gap_raw[a] = '0;
         end
         s2_gap_in[a] = (gap_raw[a] > GAP_SAT_S) ? GAP_SAT : GAP_W'(gap_raw[a]);
      end
   end

   // Stage 3: square each gap
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         s3_sq_in[a] = D2_W'(s2_gap_ff[a]) * D2_W'(s2_gap_ff[a]);
      end
   end

   // Stage 4: squared distance
   assign s4_d2_in = s3_sq_ff[0] + s3_sq_ff[1] + s3_sq_ff[2];

   // Stage 5: distance bands and the 1 m floor
   always_comb begin
      priority if (s4_d2_ff >= BAND_4) begin
         s5_dist_in = LOD_4;
      end else if (s4_d2_ff >= BAND_3) begin
         s5_dist_in = LOD_3;
      end else if (s4_d2_ff >= BAND_2) begin
         s5_dist_in = LOD_2;
      end else if (s4_d2_ff >= BAND_1) begin
         s5_dist_in = LOD_1;
      end else begin
         s5_dist_in = LOD_0;
      end
      s5_dfl_in = (s4_d2_ff < D2_FLOOR) ? D2_FLOOR : s4_d2_ff;
   end

   // Stage 6: partial products of threshold term times floored distance
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         s6_hh_in[l] = PP_W'(tcell[l][T_W-1:T_SPLIT]) * PP_W'(s5_dfl_ff[D2_W-1:D_SPLIT]);
         s6_hl_in[l] = PP_W'(tcell[l][T_W-1:T_SPLIT]) * PP_W'(s5_dfl_ff[D_SPLIT-1:0]);
         s6_lh_in[l] = PP_W'(tcell[l][T_SPLIT-1:0]) * PP_W'(s5_dfl_ff[D2_W-1:D_SPLIT]);
         s6_ll_in[l] = PP_W'(tcell[l][T_SPLIT-1:0]) * PP_W'(s5_dfl_ff[D_SPLIT-1:0]);
      end
   end

   // Stage 7: sum the partial products per level
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         s7_rhs_in[l] = (RHS_W'(s6_hh_ff[l]) << (T_SPLIT + D_SPLIT))
                      + (RHS_W'(s6_hl_ff[l]) << T_SPLIT)
                      + (RHS_W'(s6_lh_ff[l]) << D_SPLIT)
                      + RHS_W'(s6_ll_ff[l]);
      end
   end

   // Output: finest passing level, then the coarser of error and distance
   always_comb begin
      err_lod = LOD_4;
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_pass[l] = CW'(lhs) >= CW'(s7_rhs_ff[l]);
      end
      for (int l = NUM_LANES - 1; l >= 0; l--) begin
         if (lane_pass[l]) begin
            err_lod = LOD_W'(l);
         end
      end
      rsp_detail_level_in = (err_lod > s7_dist_ff) ? err_lod : s7_dist_ff;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s0_chunk_ff         <= req_chunk;
      s1_lo_ff            <= s1_lo_in;
      s1_hi_ff            <= s1_hi_in;
      s2_gap_ff           <= s2_gap_in;
      s3_sq_ff            <= s3_sq_in;
      s4_d2_ff            <= s4_d2_in;
      s5_dfl_ff           <= s5_dfl_in;
      s5_dist_ff          <= s5_dist_in;
      s6_hh_ff            <= s6_hh_in;
      s6_hl_ff            <= s6_hl_in;
      s6_lh_ff            <= s6_lh_in;
      s6_ll_ff            <= s6_ll_in;
      s6_dist_ff          <= s5_dist_ff;
      s7_rhs_ff           <= s7_rhs_in;
      s7_dist_ff          <= s6_dist_ff;
      rsp_detail_level_ff <= rsp_detail_level_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_detail_level = rsp_detail_level_ff;

   // Every taken item comes out exactly once, a fixed time later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == $past(req_accept, LATENCY))
      else $error("result strobe does not match item taken %0d cycles ago", LATENCY);

   // Level stays within the coarsest level
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_detail_level_ff <= LOD_4))
      else $error("detail level out of range");

   // Result is never finer than the distance band
   a_not_finer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_detail_level_ff >= $past(s7_dist_ff)))
      else $error("detail level finer than distance band");

   // Coarser levels have fewer cells, so a pass at one level implies the next
   a_lane_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTAGE-1] |->
         ((lane_pass[NUM_LANES-2:0] & ~lane_pass[NUM_LANES-1:1]) == '0))
      else $error("error test passes at a level but fails at a coarser one");

endmodule

`default_nettype wire

// File: dv/terrain_chunk_lod_select_core_tb.sv
// ----------------------------------------------------------------------------
// terrain_chunk_lod_select_core_tb
// Drives chunk grid indexes into the level-of-detail selector under several
// camera, pixel-scale and threshold settings, predicts each detail level from
// the clamped camera distance and the exact squared error test, and compares
// every returned level in order against the prediction.
// ----------------------------------------------------------------------------
module terrain_chunk_lod_select_core_tb
   import tclod_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHUNK_METERS   = 32;
   localparam int FINEST_CELLS   = 32;
   localparam int CHUNK_Q8_SHIFT = $clog2(CHUNK_METERS * 256);
   localparam int STALL_LIMIT    = 2000;
   localparam int GAP_PERCENT    = 17;
   localparam int PHASE_ITEMS    = 122;

   localparam logic signed [CHUNK_W-1:0] IDX_MAX = {1'b0, {(CHUNK_W-1){1'b1}}};
   localparam logic signed [CHUNK_W-1:0] IDX_MIN = {1'b1, {(CHUNK_W-1){1'b0}}};
   localparam logic [CAM_W-1:0]          CAM_MAX = {1'b0, {(CAM_W-1){1'b1}}};
   localparam logic [CAM_W-1:0]          CAM_MIN = {1'b1, {(CAM_W-1){1'b0}}};
   localparam logic [PS_W-1:0]           PS_MAX  = '1;
   localparam logic [THR_W-1:0]          THR_MAX = '1;

   // Register indexes past the list; writes there must change nothing
   localparam int CSR_SPARE_LO = int'(CSR_ERROR_THRESHOLD) + 1;
   localparam int CSR_SPARE_HI = (1 << CSR_INDEX_W) - 1;

   typedef enum logic [1:0] {
      STEP_CHUNK,
      STEP_CSR,
      STEP_DRAIN
   } step_kind_type;

   typedef struct packed {
      step_kind_type               kind;
      logic signed [CHUNK_W-1:0]   x;
      logic signed [CHUNK_W-1:0]   y;
      logic signed [CHUNK_W-1:0]   z;
      logic [CSR_INDEX_W-1:0]      index;
      logic [CSR_DATA_W-1:0]       data;
      bit                          gappy;
   } step_type;

   logic                         clock;
   logic                         reset            = 1'b1;
   logic                         start            = 1'b0;
   logic                         busy;
   logic signed [CHUNK_W-1:0]    req_chunk_x      = '0;
   logic signed [CHUNK_W-1:0]    req_chunk_y      = '0;
   logic signed [CHUNK_W-1:0]    req_chunk_z      = '0;
   logic                         rsp_valid;
   logic [LOD_W-1:0]             rsp_detail_level;
   logic                         csr_valid        = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index        = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata        = '0;

   step_type                     plan_q[$];
   logic [LOD_W-1:0]             lod_expect_q[$];
   int                           errors = 0;
   int                           stall_cycles = 0;

   // Register copies as the block should hold them
   logic signed [CAM_W-1:0]      shadow_cam_x = '0;
   logic signed [CAM_W-1:0]      shadow_cam_y = '0;
   logic signed [CAM_W-1:0]      shadow_cam_z = '0;
   logic [PS_W-1:0]              shadow_pix_scale = PS_RESET;
   logic [THR_W-1:0]             shadow_err_thr = THR_RESET;

   terrain_chunk_lod_select_core #(
      .CHUNK_METERS (CHUNK_METERS),
      .FINEST_CELLS (FINEST_CELLS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_chunk_x      (req_chunk_x),
      .req_chunk_y      (req_chunk_y),
      .req_chunk_z      (req_chunk_z),
      .rsp_valid        (rsp_valid),
      .rsp_detail_level (rsp_detail_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap from camera to the chunk cube along one axis, Q8 meters, saturated
   function automatic logic [GAP_W-1:0] axis_gap_q8(input logic signed [CAM_W-1:0] cam,
                                                    input logic signed [CHUNK_W-1:0] idx);
      longint lo, hi, c, g;
      lo = longint'(idx) * CHUNK_METERS * 256;
      hi = lo + CHUNK_METERS * 256;
      c  = longint'(cam);
      g  = 0;
      if (c < lo) begin
         g = lo - c;
      end else if (c > hi) begin
         g = c - hi;
      end
      if (g > longint'(GAP_SAT)) begin
         g = longint'(GAP_SAT);
      end
      return g[GAP_W-1:0];
   endfunction

   // Coarser of the distance-band level and the screen-space error level
   function automatic logic [LOD_W-1:0] predict_lod(input logic signed [CHUNK_W-1:0] cx,
                                                    input logic signed [CHUNK_W-1:0] cy,
                                                    input logic signed [CHUNK_W-1:0] cz);
      logic [127:0]     gx, gy, gz, d2, dfl, lhs, rhs;
      logic [LOD_W-1:0] dist_lvl, err_lvl;
      int               cells;
      gx = 128'(axis_gap_q8(shadow_cam_x, cx));
      gy = 128'(axis_gap_q8(shadow_cam_y, cy));
      gz = 128'(axis_gap_q8(shadow_cam_z, cz));
      d2 = gx * gx + gy * gy + gz * gz;
      if (d2 >= 128'(BAND_4)) begin
         dist_lvl = LOD_4;
      end else if (d2 >= 128'(BAND_3)) begin
         dist_lvl = LOD_3;
      end else if (d2 >= 128'(BAND_2)) begin
         dist_lvl = LOD_2;
      end else if (d2 >= 128'(BAND_1)) begin
         dist_lvl = LOD_1;
      end else begin
         dist_lvl = LOD_0;
      end
      // floor the distance at 1 m for the error test
      dfl = (d2 < 128'(D2_FLOOR)) ? 128'(D2_FLOOR) : d2;
      lhs = 128'(3 * CHUNK_METERS * CHUNK_METERS) * 128'(65536)
            * 128'(shadow_pix_scale) * 128'(shadow_pix_scale);
      // walk from coarse to fine so the finest passing level wins
      err_lvl = LOD_4;
      for (int lvl = 3; lvl >= 0; lvl--) begin
         cells = FINEST_CELLS >> lvl;
         if (cells < 1) begin
            cells = 1;
         end
         rhs = 128'(shadow_err_thr) * 128'(shadow_err_thr) * 128'(cells) * 128'(cells) * dfl;
         if (lhs >= rhs) begin
            err_lvl = lvl[LOD_W-1:0];
         end
      end
      return (err_lvl > dist_lvl) ? err_lvl : dist_lvl;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_word34();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[CSR_DATA_W-1:0];
   endfunction

   // Chunk index near the camera most of the time, anywhere otherwise
   function automatic logic signed [CHUNK_W-1:0] pick_index(input logic signed [CAM_W-1:0] cam);
      longint      base;
      longint      off;
      int          k;
      logic [31:0] r;
      base = longint'(cam) >>> CHUNK_Q8_SHIFT;
      case ($urandom_range(0, 9))
         0: begin
            r = $urandom;
            base = longint'(r);
         end
         1, 2: begin
         end
         default: begin
            k    = $urandom_range(0, 6);
            off  = longint'($urandom_range(0, 2 * (1 << k))) - longint'(1 << k);
            base = base + off;
         end
      endcase
      return base[CHUNK_W-1:0];
   endfunction

   task automatic add_chunk(input logic signed [CHUNK_W-1:0] x,
                            input logic signed [CHUNK_W-1:0] y,
                            input logic signed [CHUNK_W-1:0] z,
                            input bit gappy);
      step_type s;
      s = '{kind: STEP_CHUNK, x: x, y: y, z: z, index: '0, data: '0, gappy: gappy};
      plan_q.push_back(s);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      step_type s;
      s = '{kind: STEP_CSR, x: '0, y: '0, z: '0, index: index, data: data, gappy: 1'b0};
      plan_q.push_back(s);
   endtask

   task automatic add_drain();
      step_type s;
      s = '{kind: STEP_DRAIN, x: '0, y: '0, z: '0, index: '0, data: '0, gappy: 1'b0};
      plan_q.push_back(s);
   endtask

   // Build the whole plan, release reset, then wait for the block to empty
   initial begin : stimulus
      logic signed [CAM_W-1:0]  cam_x, cam_y, cam_z;
      logic [CSR_DATA_W-1:0]    word;
      logic [31:0]              r;
      bit                       gappy;

      // Directed: reset settings, camera at the origin
      add_chunk(0, 0, 0, 1'b0);                 // camera on the low corner
      add_chunk(-1, -1, -1, 1'b0);              // camera on the high corner
      add_chunk(IDX_MAX, IDX_MAX, IDX_MAX, 1'b0);
      add_chunk(IDX_MIN, IDX_MIN, IDX_MIN, 1'b0);
      add_chunk(IDX_MAX, 0, IDX_MIN, 1'b0);
      add_chunk(4, 0, 0, 1'b0);                 // exactly on each band edge
      add_chunk(-5, 0, 0, 1'b0);
      add_chunk(0, 8, 0, 1'b0);
      add_chunk(0, 0, 16, 1'b0);
      add_chunk(32, 0, 0, 1'b0);
      add_chunk(63, 0, 0, 1'b0);                // beyond 2000 m
      add_chunk(3, 0, 0, 1'b0);
      add_chunk(3, 3, 3, 1'b0);

      // zero threshold: the error test always passes
      add_csr(CSR_ERROR_THRESHOLD, '0);
      add_chunk(0, 0, 1, 1'b0);
      add_chunk(2, 2, 2, 1'b0);

      // zero pixel scale with the largest threshold: error test never passes
      add_csr(CSR_ERROR_THRESHOLD, CSR_DATA_W'(THR_MAX));
      add_csr(CSR_PIXEL_SCALE, '0);
      add_chunk(0, 0, 0, 1'b0);

      // largest pixel scale, smallest nonzero threshold
      add_csr(CSR_PIXEL_SCALE, CSR_DATA_W'(PS_MAX));
      add_csr(CSR_ERROR_THRESHOLD, CSR_DATA_W'(1));
      add_chunk(2, 0, 0, 1'b0);

      // writes past the register list must be dropped
      for (int i = CSR_SPARE_LO; i <= CSR_SPARE_HI; i++) begin
         add_csr(i[CSR_INDEX_W-1:0], rand_word34());
      end
      add_chunk(0, 0, 0, 1'b0);

      // camera at the extremes of its range
      add_csr(CSR_CAMERA_X, CAM_MIN);
      add_csr(CSR_CAMERA_Y, CAM_MAX);
      add_csr(CSR_CAMERA_Z, '0);
      add_chunk(IDX_MIN, IDX_MAX, 0, 1'b0);
      add_chunk(0, 0, 0, 1'b0);

      // Random phases, each under fresh settings
      for (int p = 0; p < 6; p++) begin
         if (p == 5) begin
            // camera near the edges of the chunk index range
            cam_x = CAM_W'(longint'(IDX_MAX) <<< CHUNK_Q8_SHIFT) + CAM_W'(100);
            cam_y = CAM_W'(longint'(IDX_MIN) <<< CHUNK_Q8_SHIFT);
            cam_z = CAM_MAX;
         end else begin
            cam_x = $signed(rand_word34()) >>> $urandom_range(1, 12);
            cam_y = $signed(rand_word34()) >>> $urandom_range(1, 12);
            cam_z = $signed(rand_word34()) >>> $urandom_range(1, 12);
         end
         add_csr(CSR_CAMERA_X, cam_x);
         add_csr(CSR_CAMERA_Y, cam_y);
         add_csr(CSR_CAMERA_Z, cam_z);

         // scale and threshold spread over many magnitudes; junk in the upper bits
         word = rand_word34();
         if (p == 0) begin
            word[PS_W-1:0] = PS_RESET;
         end else begin
            r = $urandom >> (32 - PS_W);
            word[PS_W-1:0] = PS_W'(r >> $urandom_range(0, 12));
         end
         add_csr(CSR_PIXEL_SCALE, word);
         word = rand_word34();
         if (p == 0) begin
            word[THR_W-1:0] = THR_RESET;
         end else begin
            r = $urandom >> (32 - THR_W);
            word[THR_W-1:0] = THR_W'(r >> $urandom_range(0, 10));
         end
         add_csr(CSR_ERROR_THRESHOLD, word);
         if (p % 2 == 1) begin
            add_csr(CSR_INDEX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), rand_word34());
         end

         gappy = (p != 1 && p != 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == PHASE_ITEMS / 2) begin
               add_drain();
            end
            add_chunk(pick_index(cam_x), pick_index(cam_y), pick_index(cam_z), gappy);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0 || start || csr_valid || lod_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Driver: retire accepted items and writes, then issue the next step
   always @(posedge clock) begin : drive_items
      step_type nxt;
      logic     took_item, took_csr, go_start, go_csr;
      took_item = start && !busy;
      took_csr  = csr_valid && csr_ready;
      go_start  = start && !took_item;
      go_csr    = csr_valid && !took_csr;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (took_item) begin
            lod_expect_q.push_back(predict_lod(req_chunk_x, req_chunk_y, req_chunk_z));
         end
         if (took_csr) begin
            case (csr_index)
               CSR_CAMERA_X:        shadow_cam_x     = csr_wdata[CAM_W-1:0];
               CSR_CAMERA_Y:        shadow_cam_y     = csr_wdata[CAM_W-1:0];
               CSR_CAMERA_Z:        shadow_cam_z     = csr_wdata[CAM_W-1:0];
               CSR_PIXEL_SCALE:     shadow_pix_scale = csr_wdata[PS_W-1:0];
               CSR_ERROR_THRESHOLD: shadow_err_thr   = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (!go_start && !go_csr && plan_q.size() != 0) begin
            nxt = plan_q[0];
            case (nxt.kind)
               STEP_CHUNK: begin
                  // idle now and then when the phase allows it
                  if (!nxt.gappy || $urandom_range(0, 99) >= GAP_PERCENT) begin
                     go_start = 1'b1;
                     req_chunk_x <= nxt.x;
                     req_chunk_y <= nxt.y;
                     req_chunk_z <= nxt.z;
                     void'(plan_q.pop_front());
                  end
               end
               STEP_CSR: begin
                  // write only once every level in flight has come back
                  if (lod_expect_q.size() == 0) begin
                     go_csr = 1'b1;
                     csr_index <= nxt.index;
                     csr_wdata <= nxt.data;
                     void'(plan_q.pop_front());
                  end
               end
               default: begin
                  if (lod_expect_q.size() == 0) begin
                     void'(plan_q.pop_front());
                  end
               end
            endcase
         end
         start     <= go_start;
         csr_valid <= go_csr;
      end
   end

   // Monitor: compare each returned level with the oldest prediction
   always @(posedge clock) begin : check_levels
      logic [LOD_W-1:0] want;
      if (!reset && rsp_valid === 1'b1) begin
         if (lod_expect_q.size() == 0) begin
            $error("detail_level: expected none, got %0d", rsp_detail_level);
            errors++;
         end else begin
            want = lod_expect_q.pop_front();
            if (rsp_detail_level !== want) begin
               $error("detail_level: expected %0d, got %0d", want, rsp_detail_level);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles in which nothing moves
   always @(posedge clock) begin
      if ((start && !busy) || (csr_valid && csr_ready) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
